@@ design/fud_pkg.sv @@
// shared types and character constants for the form-urlencoded decoder
// no dependencies; used by all decoder modules
`default_nettype none
package fud_pkg;

	localparam logic [7:0] CH_EQUALS  = 8'h3d;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [3:0] HEX_ALPHA_BASE = 4'ha;

	typedef struct packed {
		logic       mode;
		logic [7:0] byte_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       in_value;
		logic       pair_end;
	} out_item_t;

	// {not_hex, nibble}
	typedef struct packed {
		logic       bad;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_value(logic [7:0] b);
		hex_t h;
		h.bad = 1'b0;
		h.nib = b[3:0];
		if (b >= 8'h30 && b <= 8'h39) begin
			h.nib = b[3:0];
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			// 'a'/'A' have low nibble 1
			h.nib = 4'(b[3:0] - 4'd1 + HEX_ALPHA_BASE);
		end else begin
			h.bad = 1'b1;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

@@ design/fud_if.sv @@
// valid/ready channel interfaces for decoder input and result items
// depends on nothing but plain logic types
`default_nettype none
interface fud_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_in;

	modport source (output valid, output mode, output byte_in, input ready);
	modport sink (input valid, input mode, input byte_in, output ready);
endinterface

interface fud_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       in_value;
	logic       pair_end;

	modport source (output valid, output char_out, output in_value, output pair_end,
		input ready);
	modport sink (input valid, input char_out, input in_value, input pair_end,
		output ready);
endinterface
`default_nettype wire

@@ design/fud_in_reg.sv @@
// input register stage of the decoder
// depends on fud_pkg and fud_in_if
`default_nettype none
module fud_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	fud_in_if.sink             in_ch,
	input  wire logic          adv,
	output fud_pkg::in_item_t  item_s1,
	output logic               v_s1
);

	assign in_ch.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.mode    <= in_ch.mode;
			item_s1.byte_in <= in_ch.byte_in;
		end
	end

endmodule
`default_nettype wire

@@ design/fud_core.sv @@
// decode step: phase and escape state plus the per-byte decision logic
// depends on fud_pkg
`default_nettype none
module fud_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                v_s1,
	input  wire fud_pkg::in_item_t   item_s1,
	input  wire logic                out_free,
	output logic                     adv,
	output logic                     res_v,
	output fud_pkg::out_item_t       res
);

	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_FIRST  = 2'd1,
		ESC_SECOND = 2'd2
	} esc_t;

	esc_t         esc_q, esc_d;
	logic         phase_q, phase_d;
	logic [3:0]   nib_q, nib_d;
	logic         has;
	logic         plain;
	fud_pkg::hex_t h;
	logic [7:0]   b;

	assign b = item_s1.byte_in;
	assign h = fud_pkg::hex_value(b);

	always_comb begin
		esc_d    = esc_q;
		phase_d  = phase_q;
		nib_d    = nib_q;
		has      = 1'b0;
		plain    = 1'b0;
		res.char_out = 8'h00;
		res.in_value = phase_q;
		res.pair_end = 1'b0;
		if (item_s1.mode) begin
			// end of body closes the pair and returns to reset state
			has          = 1'b1;
			res.pair_end = 1'b1;
			esc_d        = ESC_NONE;
			phase_d      = 1'b0;
			nib_d        = 4'h0;
		end else begin
			case (esc_q)
				ESC_FIRST: begin
					if (!h.bad) begin
						nib_d = h.nib;
						esc_d = ESC_SECOND;
					end else begin
						esc_d = ESC_NONE;
						plain = 1'b1;
					end
				end
				ESC_SECOND: begin
					esc_d = ESC_NONE;
					if (!h.bad) begin
						res.char_out = {nib_q, h.nib};
						has = ({nib_q, h.nib} != 8'h00);
					end else begin
						plain = 1'b1;
					end
				end
				default: begin
					esc_d = ESC_NONE;
					plain = 1'b1;
				end
			endcase
			if (plain) begin
				if (b == fud_pkg::CH_PERCENT) begin
					esc_d = ESC_FIRST;
				end else if (b == fud_pkg::CH_PLUS) begin
					has = 1'b1;
					res.char_out = fud_pkg::CH_SPACE;
				end else if (!phase_q) begin
					if (b == fud_pkg::CH_EQUALS) begin
						phase_d = 1'b1;
					end else begin
						has = 1'b1;
						res.char_out = b;
					end
				end else if (b == fud_pkg::CH_AMP) begin
					has = 1'b1;
					res.pair_end = 1'b1;
					phase_d = 1'b0;
				end else begin
					has = 1'b1;
					res.char_out = b;
				end
			end
		end
	end

	// an item with no result never waits on the output side
	assign adv   = v_s1 && (out_free || !has);
	assign res_v = adv && has;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= ESC_NONE;
			phase_q <= 1'b0;
			nib_q   <= 4'h0;
		end else if (adv) begin
			esc_q   <= esc_d;
			phase_q <= phase_d;
			nib_q   <= nib_d;
		end
	end

`ifndef ASSERT_OFF
	a_eob_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.mode |=> esc_q == ESC_NONE && !phase_q)
		else $error("state not cleared after end of body");
	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		adv && esc_q != ESC_FIRST |=> esc_q != ESC_SECOND)
		else $error("second escape digit stage entered without first");
	a_pair_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_v && res.pair_end |-> res.char_out == 8'h00)
		else $error("pair end result carries a character");
	a_amp_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_v && res.pair_end && !item_s1.mode |-> res.in_value && !phase_d)
		else $error("ampersand pair end outside value phase");
`endif

endmodule
`default_nettype wire

@@ design/fud_out_reg.sv @@
// result register driving the output channel
// depends on fud_pkg and fud_out_if
`default_nettype none
module fud_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_v,
	input  wire fud_pkg::out_item_t  res,
	output logic                     out_free,
	fud_out_if.source                out_ch
);

	logic               v_q;
	fud_pkg::out_item_t data_q;

	assign out_free = !v_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (out_free) begin
			v_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			data_q <= res;
		end
	end

	assign out_ch.valid    = v_q;
	assign out_ch.char_out = data_q.char_out;
	assign out_ch.in_value = data_q.in_value;
	assign out_ch.pair_end = data_q.pair_end;

endmodule
`default_nettype wire

@@ design/form_urlencoded_decoder.sv @@
// form-urlencoded body decoder: one byte per item, tagged name/value characters out
// path: an accepted item passes the input register, then the result register, before its result is valid
// throughput: one item per cycle while the result register is free, set by the state update in fud_core
// results are held in the result register while the sink stalls; input keeps flowing
// for items that give no result
// reset: arst_n clears valid flags, name phase and escape state at once
`default_nettype none
module form_urlencoded_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	fud_in_if.sink    in_ch,
	fud_out_if.source out_ch
);

	fud_pkg::in_item_t  item_s1;
	fud_pkg::out_item_t res;
	logic               v_s1;
	logic               adv;
	logic               res_v;
	logic               out_free;

	fud_in_reg u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.adv     (adv),
		.item_s1 (item_s1),
		.v_s1    (v_s1)
	);

	fud_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.adv      (adv),
		.res_v    (res_v),
		.res      (res)
	);

	fud_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_v    (res_v),
		.res      (res),
		.out_free (out_free),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

@@ bench/tb_form_urlencoded_decoder.sv @@
// self-checking bench for form_urlencoded_decoder: directed bodies, then random traffic
// depends on fud_pkg, fud_in_if and fud_out_if; predicts each decoded item inline
`default_nettype none
module tb_form_urlencoded_decoder;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_END = 1'b1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {ESC_NONE, ESC_FIRST, ESC_SECOND} esc_stage_t;

	logic clk;
	logic arst_n;

	fud_in_if in_ch ();
	fud_out_if out_ch ();

	form_urlencoded_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// decoder state mirrored by the predictor
	logic       value_phase;
	esc_stage_t esc_stage;
	logic [3:0] esc_high;

	fud_pkg::out_item_t pending_chars[$];
	int unsigned error_count;
	int unsigned bytes_sent;
	int unsigned cycle_count;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] b);
		if (b inside {[8'h30:8'h39]})
			return {1'b0, 4'(b - 8'h30)};
		if (b inside {[8'h41:8'h46]})
			return {1'b0, 4'(b - 8'h41 + 8'd10)};
		if (b inside {[8'h61:8'h66]})
			return {1'b0, 4'(b - 8'h61 + 8'd10)};
		return 5'h10;
	endfunction

	function automatic void expect_char(input logic [7:0] ch, input logic val,
		input logic pend);
		fud_pkg::out_item_t r;
		r.char_out = ch;
		r.in_value = val;
		r.pair_end = pend;
		pending_chars = {pending_chars, r};
	endfunction

	function automatic void decode_item(input logic mode, input logic [7:0] b);
		logic [4:0] h;
		logic       plain;
		plain = 1'b1;
		if (mode == MODE_END) begin
			expect_char(8'h00, value_phase, 1'b1);
			value_phase = 1'b0;
			esc_stage = ESC_NONE;
			esc_high = 4'h0;
			plain = 1'b0;
		end else begin
			case (esc_stage)
				ESC_FIRST: begin
					h = nibble_of(b);
					if (!h[4]) begin
						esc_high = h[3:0];
						esc_stage = ESC_SECOND;
						plain = 1'b0;
					end else begin
						esc_stage = ESC_NONE;
					end
				end
				ESC_SECOND: begin
					h = nibble_of(b);
					esc_stage = ESC_NONE;
					if (!h[4]) begin
						plain = 1'b0;
						// decoded zero is swallowed
						if ({esc_high, h[3:0]} != 8'h00)
							expect_char({esc_high, h[3:0]}, value_phase, 1'b0);
					end
				end
				default: esc_stage = ESC_NONE;
			endcase
		end
		if (plain) begin
			if (b == fud_pkg::CH_PERCENT)
				esc_stage = ESC_FIRST;
			else if (b == fud_pkg::CH_PLUS)
				expect_char(fud_pkg::CH_SPACE, value_phase, 1'b0);
			else if (!value_phase && b == fud_pkg::CH_EQUALS)
				value_phase = 1'b1;
			else if (value_phase && b == fud_pkg::CH_AMP) begin
				value_phase = 1'b0;
				expect_char(8'h00, 1'b1, 1'b1);
			end else
				expect_char(b, value_phase, 1'b0);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			decode_item(in_ch.mode, in_ch.byte_in);
	end

	function automatic void compare_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		fud_pkg::out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected item, expected none, got char %h value %b end %b",
					$time, out_ch.char_out, out_ch.in_value, out_ch.pair_end);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				compare_field("char_out", want.char_out, out_ch.char_out);
				compare_field("in_value", 8'(want.in_value), 8'(out_ch.in_value));
				compare_field("pair_end", 8'(want.pair_end), 8'(out_ch.pair_end));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// valid stays high on return so back-to-back items need no second assignment
	task automatic send_item(input logic mode, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.byte_in <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(MODE_BYTE, s[i]);
	endtask

	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'(8'h30 + v);
		return $urandom_range(0, 1) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
	endfunction

	task automatic test_directed();
		send_item(MODE_END, 8'hff);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'hff);
		// stray '&', '+', stray '=', decoded '=', mixed case, decoded zero,
		// bad first digit, bad second digit on '&', '%' after '%'
		send_text("&=+=%3D%Ff%00%g%4&%%41=%");
		// ends in value phase with an escape pending
		send_item(MODE_END, 8'h00);
		wait_for_results();
	endtask

	task automatic test_random_bodies(input int n_items, input int idle_pct,
		input int stall_pct);
		int unsigned target;
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = bytes_sent + n_items;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				send_item(MODE_END, 8'($urandom_range(0, 255)));
			else if (pick < 16)
				send_item(MODE_BYTE, fud_pkg::CH_AMP);
			else if (pick < 24)
				send_item(MODE_BYTE, fud_pkg::CH_EQUALS);
			else if (pick < 32)
				send_item(MODE_BYTE, fud_pkg::CH_PLUS);
			else if (pick < 58) begin
				send_item(MODE_BYTE, fud_pkg::CH_PERCENT);
				if ($urandom_range(0, 9) == 0)
					send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
				else begin
					send_item(MODE_BYTE, random_hex_char());
					if ($urandom_range(0, 4) == 0)
						send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
					else
						send_item(MODE_BYTE, random_hex_char());
				end
			end else if (pick < 80)
				send_item(MODE_BYTE, 8'($urandom_range(8'h61, 8'h7a)));
			else
				send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
		end
		// sender holds off until every outstanding item is back
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_BYTE;
		in_ch.byte_in = 8'h00;
		out_ch.ready = 1'b0;
		value_phase = 1'b0;
		esc_stage = ESC_NONE;
		esc_high = 4'h0;
		error_count = 0;
		bytes_sent = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_bodies(300, 35, 64);
		test_random_bodies(300, 64, 35);
		test_random_bodies(300, 0, 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
